### rtl/gbn_pkg.sv
// Package for the go-back-N link endpoint: field widths, operation and
// result codes, and the result structures shared by the top level and the
// output buffer. Depends on nothing.
package gbn_pkg;

  localparam int SEQ_W      = 32;
  localparam int PAY_W      = 32;
  localparam int OP_W       = 3;
  localparam int KIND_W     = 3;
  localparam int KA_W       = 16;
  localparam int WINDOW_DEF = 16;

  // Input operation codes.
  localparam logic [OP_W-1:0] OP_SEND  = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA  = 3'd1;
  localparam logic [OP_W-1:0] OP_ACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_OTHER = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK  = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET = 3'd5;

  // Result kinds.
  localparam logic [KIND_W-1:0] K_DATA      = 3'd0;
  localparam logic [KIND_W-1:0] K_ACK       = 3'd1;
  localparam logic [KIND_W-1:0] K_KEEPALIVE = 3'd2;
  localparam logic [KIND_W-1:0] K_DELIVER   = 3'd3;
  localparam logic [KIND_W-1:0] K_TIMEOUT   = 3'd4;
  localparam logic [KIND_W-1:0] K_REJECT    = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [PAY_W-1:0]  payload;
    logic              last;
  } result_t;

  // Up to two results produced by one item, in order.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } res_pair_t;

  // Output buffer status seen by the sequencer.
  typedef struct packed {
    logic take;        // output register can load this cycle
    logic pend_clear;  // pending slot is empty after this cycle
  } ob_status_t;

endpackage

### rtl/gbn_outbuf.sv
// Output register with one pending slot for the go-back-N endpoint.
// Holds up to two results of one item and hands them out in order.
// Depends on gbn_pkg.
module gbn_outbuf (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load_i,
  input  gbn_pkg::res_pair_t              pair_i,
  output gbn_pkg::ob_status_t             status_o,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gbn_pkg::KIND_W-1:0]      out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]       out_seq,
  output logic [gbn_pkg::PAY_W-1:0]       out_payload,
  output logic                            out_last
);
  import gbn_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    pend_v_r, pend_v_nxt;
  result_t pend_res_r, pend_res_nxt;
  logic    take;

  assign take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    pend_v_nxt    = pend_v_r;
    pend_res_nxt  = pend_res_r;
    // A load only comes with the pending slot empty and the register free.
    if (load_i) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = pair_i.r0;
      pend_v_nxt    = (pair_i.cnt == 2'd2);
      pend_res_nxt  = pair_i.r1;
    end else if (take) begin
      out_valid_nxt = pend_v_r;
      out_res_nxt   = pend_res_r;
      pend_v_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_v_r    <= pend_v_nxt;
    end
    out_res_r  <= out_res_nxt;
    pend_res_r <= pend_res_nxt;
  end

  assign status_o.take       = take;
  assign status_o.pend_clear = !pend_v_r || take;

  assign out_valid   = out_valid_r;
  assign out_kind    = out_res_r.kind;
  assign out_seq     = out_res_r.seq;
  assign out_payload = out_res_r.payload;
  assign out_last    = out_res_r.last;

endmodule

### rtl/go_back_n_link_endpoint.sv
// Go-back-N link endpoint: sequencer, retransmit ring memory and link state.
// Depends on gbn_pkg and gbn_outbuf.
//
// Usage. Each input transfer carries an operation (send a new handle, data
// frame received, ack received, other frame received, interval tick, link
// reset) with a payload handle and a sequence number. Each item yields zero,
// one or two result transfers on the output channel; the final one of an item
// has out_last set. The keep-alive register is written through the cfg_
// channel while the endpoint is idle; a write also reloads the keep-alive
// countdown.
// Timing. Taking an item also issues the read of the retransmit ring (a
// synchronous memory); the item executes in the EXEC state, once the output
// register can take its first result, which then enters it. A new item is
// taken only after the last one has executed. While the receiver keeps up, a
// second result (in-order data: ack plus delivery) moves from the single
// pending slot into the output register at the edge the next item is taken.
// Reset clears all link state and the keep-alive register; the ring needs no
// clearing, since only entries written since are ever read. While out_stall
// is high, results hold; one more item with results can be taken and then
// waits for the output register, and in_stall stays high until the output moves.
module go_back_n_link_endpoint #(
  parameter int WINDOW = gbn_pkg::WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gbn_pkg::OP_W-1:0]        in_op,
  input  logic [gbn_pkg::PAY_W-1:0]       in_payload,
  input  logic [gbn_pkg::SEQ_W-1:0]       in_seq,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gbn_pkg::KIND_W-1:0]      out_kind,
  output logic [gbn_pkg::SEQ_W-1:0]       out_seq,
  output logic [gbn_pkg::PAY_W-1:0]       out_payload,
  output logic                            out_last,
  // Configuration channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gbn_pkg::KA_W-1:0]        cfg_keepalive_ticks
);
  import gbn_pkg::*;

  localparam int IW = $clog2(WINDOW);      // ring index width
  localparam int FW = $clog2(WINDOW + 1);  // fill count width, holds WINDOW
  localparam int SW = IW + 1;              // index sum before wrapping

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // Reduce an index sum below twice the window back into the ring.
  function automatic logic [IW-1:0] wrap_idx(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(WINDOW)) ? (s - SW'(WINDOW)) : s;
    return r[IW-1:0];
  endfunction

  // Sequencer and latched item.
  logic              state_r, state_nxt;
  logic [OP_W-1:0]   op_r;
  logic [PAY_W-1:0]  payload_r;
  logic [SEQ_W-1:0]  seq_r;

  // Link state.
  logic [SEQ_W-1:0]  send_seq_r, send_seq_nxt;
  logic [SEQ_W-1:0]  recv_seq_r, recv_seq_nxt;
  logic [IW-1:0]     head_r, head_nxt;
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [IW-1:0]     ridx_r, ridx_nxt;
  logic              rend_r, rend_nxt;
  logic              timer_r, timer_nxt;
  logic [KA_W-1:0]   ka_ticks_r;
  logic [KA_W-1:0]   ka_left_r, ka_left_nxt;

  // Retransmit ring.
  logic [PAY_W-1:0]  ring_mem [WINDOW];
  logic [PAY_W-1:0]  rd_data_r;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              mem_we;

  // Datapath terms.
  logic [SEQ_W-1:0]  base;
  logic [IW-1:0]     sel_idx;
  logic              full;
  logic              accept;
  logic              exec_go;
  logic              cfg_we;
  res_pair_t         res;
  ob_status_t        ob_st;

  assign accept  = in_valid && !in_stall;
  assign cfg_we  = cfg_valid && cfg_ready;
  assign in_stall  = !((state_r == ST_IDLE) && ob_st.pend_clear);
  assign cfg_ready = (state_r == ST_IDLE);

  // Oldest held number, resend position and ring addresses. These depend on
  // link state only, which does not change between taking an item and
  // executing it, so the read issued at acceptance matches the execution.
  always_comb begin
    base    = send_seq_r - SEQ_W'(fill_r) + SEQ_W'(1);
    sel_idx = (rend_r || (FW'(ridx_r) >= fill_r)) ? '0 : ridx_r;
    rd_addr = wrap_idx(SW'(head_r) + SW'(sel_idx));
    wr_addr = wrap_idx(SW'(head_r) + SW'(fill_r));
    full    = (fill_r == FW'(WINDOW));
  end

  // Execution of the latched item.
  always_comb begin
    logic [SEQ_W-1:0] diff;
    logic [FW-1:0]    drop;
    logic [FW-1:0]    ni;
    logic             ni_end;

    send_seq_nxt = send_seq_r;
    recv_seq_nxt = recv_seq_r;
    head_nxt     = head_r;
    fill_nxt     = fill_r;
    ridx_nxt     = ridx_r;
    rend_nxt     = rend_r;
    timer_nxt    = timer_r;
    ka_left_nxt  = ka_left_r;
    mem_we       = 1'b0;
    res          = '0;
    diff         = seq_r - base;
    drop         = '0;
    ni           = FW'(sel_idx) + FW'(1);
    ni_end       = (ni >= fill_r);

    // Every received frame reloads the keep-alive countdown.
    if ((op_r == OP_DATA || op_r == OP_ACK || op_r == OP_OTHER) && (ka_ticks_r != '0)) begin
      ka_left_nxt = ka_ticks_r;
    end

    unique case (op_r)
      OP_SEND: begin
        res.cnt = 2'd1;
        if (full) begin
          res.r0 = '{kind: K_REJECT, seq: '0, payload: payload_r, last: 1'b1};
        end else begin
          send_seq_nxt = send_seq_r + SEQ_W'(1);
          res.r0 = '{kind: K_DATA, seq: send_seq_nxt, payload: payload_r, last: 1'b1};
          mem_we    = 1'b1;
          fill_nxt  = fill_r + FW'(1);
          timer_nxt = 1'b1;
        end
      end
      OP_ACK: begin
        // Held numbers run up from base; drop those at or below the ack. The
        // highest possible number covers every held entry, even when the held
        // numbers wrap past zero.
        if (seq_r < base) begin
          drop = '0;
        end else if ((diff >= SEQ_W'(fill_r)) || (seq_r == '1)) begin
          drop = fill_r;
        end else begin
          drop = FW'(diff) + FW'(1);
        end
        head_nxt = wrap_idx(SW'(head_r) + SW'(drop));
        fill_nxt = fill_r - drop;
        rend_nxt = 1'b1;
        ridx_nxt = '0;
      end
      OP_DATA: begin
        if (seq_r != recv_seq_r + SEQ_W'(1)) begin
          res.cnt = 2'd1;
          res.r0  = '{kind: K_ACK, seq: recv_seq_r, payload: '0, last: 1'b1};
        end else begin
          recv_seq_nxt = recv_seq_r + SEQ_W'(1);
          res.cnt = 2'd2;
          res.r0  = '{kind: K_ACK, seq: recv_seq_nxt, payload: '0, last: 1'b0};
          res.r1  = '{kind: K_DELIVER, seq: recv_seq_nxt, payload: payload_r, last: 1'b1};
          if (ka_ticks_r != '0) begin
            timer_nxt = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (timer_r) begin
          if (fill_r == '0 && ka_ticks_r == '0) begin
            timer_nxt = 1'b0;
          end else begin
            res.cnt = 2'd1;
            if (fill_r == '0) begin
              res.r0 = '{kind: K_KEEPALIVE, seq: '0, payload: '0, last: 1'b1};
            end else begin
              res.r0 = '{kind: K_DATA, seq: base + SEQ_W'(sel_idx),
                         payload: rd_data_r, last: 1'b1};
              rend_nxt = ni_end;
              ridx_nxt = ni_end ? '0 : ni[IW-1:0];
            end
            if (ka_ticks_r != '0) begin
              if (ka_left_r != '0) begin
                ka_left_nxt = ka_left_r - KA_W'(1);
              end else begin
                res.cnt     = 2'd2;
                res.r0.last = 1'b0;
                res.r1      = '{kind: K_TIMEOUT, seq: '0, payload: '0, last: 1'b1};
                timer_nxt   = 1'b0;
              end
            end
          end
        end
      end
      OP_RESET: begin
        send_seq_nxt = '0;
        recv_seq_nxt = '0;
        head_nxt     = '0;
        fill_nxt     = '0;
        ridx_nxt     = '0;
        rend_nxt     = 1'b1;
        timer_nxt    = 1'b0;
      end
      default: begin
        // Other frames only reload the countdown; unused codes do nothing.
      end
    endcase
  end

  // An item with results executes once the output register can take the
  // first one; the pending slot is already empty by then.
  assign exec_go = (state_r == ST_EXEC) && ((res.cnt == 2'd0) || ob_st.take);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept)  state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      send_seq_r <= '0;
      recv_seq_r <= '0;
      head_r     <= '0;
      fill_r     <= '0;
      ridx_r     <= '0;
      rend_r     <= 1'b1;
      timer_r    <= 1'b0;
      ka_ticks_r <= '0;
      ka_left_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (exec_go) begin
        send_seq_r <= send_seq_nxt;
        recv_seq_r <= recv_seq_nxt;
        head_r     <= head_nxt;
        fill_r     <= fill_nxt;
        ridx_r     <= ridx_nxt;
        rend_r     <= rend_nxt;
        timer_r    <= timer_nxt;
      end
      if (cfg_we) begin
        ka_ticks_r <= cfg_keepalive_ticks;
        ka_left_r  <= cfg_keepalive_ticks;
      end else if (exec_go) begin
        ka_left_r <= ka_left_nxt;
      end
    end
  end

  // Item capture and ring read at acceptance.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r      <= in_op;
      payload_r <= in_payload;
      seq_r     <= in_seq;
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Ring write when a new handle is sent.
  always_ff @(posedge clk) begin
    if (exec_go && mem_we) begin
      ring_mem[wr_addr] <= payload_r;
    end
  end

  gbn_outbuf u_outbuf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (exec_go && (res.cnt != 2'd0)),
    .pair_i      (res),
    .status_o    (ob_st),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_seq     (out_seq),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

endmodule
